>>> design/pktt_pkg.sv
// ---------------------------------------------------------------------------
// Per-key top-track tracker package
// Widths, the black-key table and the top-track encoder shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pktt_pkg;

    localparam int NUM_TRACKS   = 64;
    localparam int NUM_KEYS     = 128;
    localparam int MASK_W       = 64;
    localparam int TRACK_W      = 6;
    localparam int KEY_W        = 7;
    localparam int KEY_IN_W     = 9;
    localparam int COLOR_W      = 7;
    localparam int COLOR_OFFSET = 2;
    localparam int KEY_MAX      = 127;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = COLOR_W'(0);
    localparam logic [COLOR_W-1:0] COLOR_BLACK = COLOR_W'(1);

    typedef enum logic {
        ACT_NOTE_ON  = 1'b0,
        ACT_NOTE_OFF = 1'b1
    } t_action;

    typedef logic [MASK_W-1:0] t_mask;

    // Outcome of one event applied to a key's track mask.
    typedef struct packed {
        logic               write;
        t_mask              new_mask;
        logic               res_valid;
        logic [COLOR_W-1:0] color;
    } t_upd;

    function automatic logic [NUM_KEYS-1:0] build_black_keys();
        logic [NUM_KEYS-1:0] tbl;
        int                  pc;
        tbl = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            pc = k % 12;
            tbl[k] = (pc == 1) || (pc == 3) || (pc == 6) || (pc == 8) || (pc == 10);
        end
        return tbl;
    endfunction

    localparam logic [NUM_KEYS-1:0] BLACK_KEYS = build_black_keys();

    // Index of the highest set bit; zero for an empty mask.
    function automatic logic [TRACK_W-1:0] top_track(input t_mask mask);
        logic [TRACK_W-1:0] t;
        t = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (mask[i]) begin
                t = TRACK_W'(i);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/pktt_evt_if.sv
// ---------------------------------------------------------------------------
// Note event channel
// Valid/ready channel that carries one note-on or note-off event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pktt_evt_if
    import pktt_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [TRACK_W-1:0]         track_id;
    logic signed [KEY_IN_W-1:0] key_number;

    modport source (output valid, output action, output track_id, output key_number,
                    input ready);
    modport sink   (input valid, input action, input track_id, input key_number,
                    output ready);
endinterface

`default_nettype wire

>>> design/pktt_upd_if.sv
// ---------------------------------------------------------------------------
// Key color update channel
// Valid/ready channel that carries one key color change.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pktt_upd_if
    import pktt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_index;
    logic [COLOR_W-1:0] color_code;

    modport source (output valid, output key_index, output color_code, input ready);
    modport sink   (input valid, input key_index, input color_code, output ready);
endinterface

`default_nettype wire

>>> design/pktt_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/pktt_update.sv
// ---------------------------------------------------------------------------
// Key mask update
// Applies one event to a key's track mask and decides the color result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pktt_update
    import pktt_pkg::*;
(
    input  wire                 i_action,
    input  wire [TRACK_W-1:0]   i_track,
    input  wire [KEY_W-1:0]     i_key,
    input  wire [MASK_W-1:0]    i_mask,
    output t_upd                o_upd
);

    t_mask              bit_sel;
    logic               held;
    logic               in_range;
    logic [TRACK_W-1:0] top_old;
    logic [TRACK_W-1:0] top_new;
    t_mask              set_mask;
    t_mask              clr_mask;

    assign in_range = (32'(i_track) < NUM_TRACKS) && (32'(i_track) < MASK_W);
    assign bit_sel  = t_mask'(1) << i_track;
    assign held     = |(i_mask & bit_sel);
    assign set_mask = i_mask | bit_sel;
    assign clr_mask = i_mask & ~bit_sel;
    assign top_old  = top_track(i_mask);
    assign top_new  = top_track(clr_mask);

    always_comb begin
        o_upd.write     = 1'b0;
        o_upd.new_mask  = i_mask;
        o_upd.res_valid = 1'b0;
        o_upd.color     = COLOR_W'(i_track) + COLOR_W'(COLOR_OFFSET);
        if (in_range) begin
            case (t_action'(i_action))
                ACT_NOTE_ON: begin
                    if (!held) begin
                        o_upd.write    = 1'b1;
                        o_upd.new_mask = set_mask;
                        // A new track under the current top changes nothing visible.
                        o_upd.res_valid = (i_mask == '0) || (top_old <= i_track);
                    end
                end
                ACT_NOTE_OFF: begin
                    if (held) begin
                        o_upd.write    = 1'b1;
                        o_upd.new_mask = clr_mask;
                        if (clr_mask == '0) begin
                            o_upd.res_valid = 1'b1;
                            o_upd.color     = BLACK_KEYS[i_key] ? COLOR_BLACK : COLOR_WHITE;
                        end else if (top_old == i_track) begin
                            o_upd.res_valid = 1'b1;
                            o_upd.color = COLOR_W'(top_new) + COLOR_W'(COLOR_OFFSET);
                        end
                    end
                end
                default: begin
                    o_upd.write = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/per_key_top_track_tracker.sv
// ---------------------------------------------------------------------------
// Per-key top-track tracker
// Keeps a track mask per key and reports color changes of each key's top track.
// ---------------------------------------------------------------------------
// Path: an event goes through the stage-1 register and then the output register.
// Throughput: one event per cycle unless the output stalls, limited by the single
// read-modify-write of the mask RAM; the last write is forwarded to the next event
// on the same key. Reset: every key reads as held by no track right after reset,
// through a per-key valid bit, so there is no clearing pass; the pipeline empties.
`timescale 1ns / 1ps
`default_nettype none

module per_key_top_track_tracker
    import pktt_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    pktt_evt_if.sink       i_evt,
    pktt_upd_if.source     o_upd
);

    logic               adv;
    logic [KEY_W-1:0]   key_sat;
    t_mask              rdata;
    t_mask              mask_cur;
    t_upd               upd;
    logic               do_write;

    logic               r_s1_valid;
    logic               r_s1_action;
    logic [TRACK_W-1:0] r_s1_track;
    logic [KEY_W-1:0]   r_s1_key;
    logic [NUM_KEYS-1:0] r_key_valid;
    logic               r_fwd_valid;
    logic [KEY_W-1:0]   r_fwd_key;
    t_mask              r_fwd_mask;
    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_key;
    logic [COLOR_W-1:0] r_out_color;

    assign adv         = !r_out_valid || o_upd.ready;
    assign i_evt.ready = adv;

    // Negative keys clamp to zero, keys above the top key clamp to it.
    always_comb begin
        if (i_evt.key_number[KEY_IN_W-1]) begin
            key_sat = '0;
        end else if (i_evt.key_number[KEY_IN_W-2]) begin
            key_sat = KEY_W'(KEY_MAX);
        end else begin
            key_sat = i_evt.key_number[KEY_W-1:0];
        end
    end

    pktt_ram #(
        .WIDTH (MASK_W),
        .DEPTH (NUM_KEYS)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_s1_key),
        .i_wdata (upd.new_mask),
        .i_re    (adv),
        .i_raddr (key_sat),
        .o_rdata (rdata)
    );

    // The RAM read may have missed the write of the event just before.
    always_comb begin
        if (r_fwd_valid && (r_fwd_key == r_s1_key)) begin
            mask_cur = r_fwd_mask;
        end else if (r_key_valid[r_s1_key]) begin
            mask_cur = rdata;
        end else begin
            mask_cur = '0;
        end
    end

    pktt_update u_update (
        .i_action (r_s1_action),
        .i_track  (r_s1_track),
        .i_key    (r_s1_key),
        .i_mask   (mask_cur),
        .o_upd    (upd)
    );

    assign do_write = adv && r_s1_valid && upd.write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_key_valid <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid  <= i_evt.valid;
                r_out_valid <= r_s1_valid && upd.res_valid;
            end
            if (do_write) begin
                r_key_valid[r_s1_key] <= 1'b1;
                r_fwd_valid           <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_action <= i_evt.action;
            r_s1_track  <= i_evt.track_id;
            r_s1_key    <= key_sat;
            r_out_key   <= r_s1_key;
            r_out_color <= upd.color;
        end
        if (do_write) begin
            r_fwd_key  <= r_s1_key;
            r_fwd_mask <= upd.new_mask;
        end
    end

    assign o_upd.valid      = r_out_valid;
    assign o_upd.key_index  = r_out_key;
    assign o_upd.color_code = r_out_color;

endmodule

`default_nettype wire
